// ===== sv/kmsm_pkg.sv =====
package kmsm_pkg;

    localparam int COLUMNS_DEFAULT    = 2048;
    localparam int MAX_HEIGHT_DEFAULT = 8;

    localparam int SELECT_W   = 32;
    localparam int LIMIT_W    = 33;
    localparam int CFG_IDX_W  = 3;
    localparam int OUTCOME_W  = 3;
    localparam int COLUMN_W   = 11;
    localparam int OCCUPIED_W = 15;
    localparam int COUNT_W    = 12;

    localparam int CELL_EMPTY     = 0;
    localparam int CELL_HEAD      = 1;
    localparam int CELL_BODY_BASE = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ADS_NO_GROUND  = 3'd0,
        CFG_ADS_ONE_GROUND = 3'd1,
        CFG_ADS_TWO_GROUND = 3'd2,
        CFG_DES_NO_GROUND  = 3'd3,
        CFG_DES_ONE_GROUND = 3'd4,
        CFG_DES_TWO_GROUND = 3'd5
    } cfg_index_t;

    typedef enum logic [OUTCOME_W-1:0] {
        OUTCOME_NONE         = 3'd0,
        OUTCOME_ADS_REJECTED = 3'd1,
        OUTCOME_ADS_DONE     = 3'd2,
        OUTCOME_ADS_UNDONE   = 3'd3,
        OUTCOME_DES_REJECTED = 3'd4,
        OUTCOME_DES_DONE     = 3'd5
    } outcome_t;

    typedef struct packed {
        logic valid;
        logic adsorbable;
        logic desorbable;
        logic last;
    } pair_flags_t;

endpackage

// ===== sv/kmsm_ram.sv =====
module kmsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wen,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/kmsm_scan.sv =====
module kmsm_scan #(
    parameter int COLUMNS    = kmsm_pkg::COLUMNS_DEFAULT,
    parameter int MAX_HEIGHT = kmsm_pkg::MAX_HEIGHT_DEFAULT
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          start,
    output logic [$clog2(COLUMNS)-1:0]                    h_raddr,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]               h_rdata,
    output logic [$clog2(COLUMNS*MAX_HEIGHT)-1:0]         c_raddr,
    input  logic [$clog2(MAX_HEIGHT+2)-1:0]               c_rdata,
    output kmsm_pkg::pair_flags_t                         pair,
    output logic [$clog2(COLUMNS)-1:0]                    pair_col,
    output logic [$clog2(MAX_HEIGHT+1)-1:0]               pair_hl,
    output logic [$clog2(MAX_HEIGHT+1)-1:0]               pair_hr
);

    localparam int CW = $clog2(COLUMNS);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int KW = $clog2(MAX_HEIGHT + 2);
    localparam int AW = $clog2(COLUMNS * MAX_HEIGHT);

    logic          run_reg;
    logic [CW:0]   k_reg;
    logic          s1_valid_reg, s1_first_reg, s1_last_reg;
    logic [CW-1:0] s1_col_reg;
    logic          s2_valid_reg, s2_first_reg, s2_last_reg;
    logic [CW-1:0] s2_col_reg;
    logic [HW-1:0] s2_h_reg;
    logic [HW-1:0] prev_h_reg;
    logic [KW-1:0] prev_c_reg;
    logic [CW-1:0] prev_col_reg;
    logic          k_end;
    logic [HW-1:0] diff;
    logic          ads;

    assign k_end   = (k_reg == (CW+1)'(COLUMNS));
    assign h_raddr = k_end ? '0 : k_reg[CW-1:0];
    assign c_raddr = AW'(s1_col_reg) * AW'(MAX_HEIGHT) + AW'(h_rdata) - AW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg      <= 1'b0;
            k_reg        <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                run_reg <= 1'b1;
                k_reg   <= '0;
            end
            else if (run_reg)
            begin
                k_reg <= k_reg + (CW+1)'(1);
                if (k_end)
                begin
                    run_reg <= 1'b0;
                end
            end
            s1_valid_reg <= run_reg;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= (k_reg == '0);
        s1_last_reg  <= k_end;
        s1_col_reg   <= h_raddr;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_col_reg   <= s1_col_reg;
        s2_h_reg     <= h_rdata;
        if (s2_valid_reg)
        begin
            prev_h_reg   <= s2_h_reg;
            prev_c_reg   <= c_rdata;
            prev_col_reg <= s2_col_reg;
        end
    end

    // pair (prev, current): left column is the previous one in the stream
    assign diff = (prev_h_reg >= s2_h_reg) ? prev_h_reg - s2_h_reg : s2_h_reg - prev_h_reg;
    assign ads  = (diff <= HW'(1));

    always_comb
    begin
        pair.valid      = s2_valid_reg && !s2_first_reg;
        pair.last       = s2_last_reg;
        pair.adsorbable = ads;
        pair.desorbable = ads && (prev_h_reg != '0) && (s2_h_reg != '0)
                          && (prev_c_reg == KW'(kmsm_pkg::CELL_HEAD))
                          && (c_rdata == KW'(prev_h_reg) + KW'(kmsm_pkg::CELL_BODY_BASE - 1));
    end

    assign pair_col = prev_col_reg;
    assign pair_hl  = prev_h_reg;
    assign pair_hr  = s2_h_reg;

endmodule

// ===== sv/kmer_stack_metropolis_step.sv =====
// Operation: a move is found by two streaming passes of COLUMNS + 1 height reads each, one to
// count, one to locate; the locate pass is skipped when there is no event. A move that writes
// back updates both columns; a rejected or overflowing move writes nothing back.
// Transactions: one at a time; the next is taken the cycle after the result is registered.
// Reset: limits, totals and heights go to zero; after reset a clearing pass over all COLUMNS
// entries zeroes the height memory while no transaction is taken.
module kmer_stack_metropolis_step #(
    parameter int COLUMNS    = kmsm_pkg::COLUMNS_DEFAULT,
    parameter int MAX_HEIGHT = kmsm_pkg::MAX_HEIGHT_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [kmsm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kmsm_pkg::LIMIT_W-1:0]       cfg_data,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic [kmsm_pkg::SELECT_W-1:0]      select_random,
    input  logic [kmsm_pkg::SELECT_W-1:0]      accept_random,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [kmsm_pkg::OUTCOME_W-1:0]     outcome,
    output logic [kmsm_pkg::COLUMN_W-1:0]      event_column,
    output logic [kmsm_pkg::OCCUPIED_W-1:0]    occupied_sites,
    output logic [kmsm_pkg::COUNT_W-1:0]       ground_sites,
    output logic [kmsm_pkg::COUNT_W-1:0]       adsorbable_pairs,
    output logic [kmsm_pkg::COUNT_W-1:0]       desorbable_dimers
);

    localparam int CW = $clog2(COLUMNS);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int KW = $clog2(MAX_HEIGHT + 2);
    localparam int AW = $clog2(COLUMNS * MAX_HEIGHT);
    localparam int NW = CW + 1;
    localparam int TW = CW + 2;
    localparam int OW = $clog2(COLUMNS * MAX_HEIGHT + 1);
    localparam int LW = kmsm_pkg::LIMIT_W;
    localparam int SW = kmsm_pkg::SELECT_W;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COUNT,
        ST_MULT,
        ST_SETUP,
        ST_LOCATE,
        ST_DECIDE,
        ST_WRITE_LEFT,
        ST_WRITE_RIGHT,
        ST_OUT
    } state_t;

    state_t                  state_reg;
    logic [LW-1:0]           ads_lim_reg [3];
    logic [LW-1:0]           des_lim_reg [3];
    logic [CW-1:0]           clr_reg;
    logic [SW-1:0]           sel_reg, acc_reg;
    logic                    start_reg;
    logic [NW-1:0]           n_ads_reg, n_des_reg;
    logic [TW+SW-1:0]        prod_reg;
    logic                    ads_reg;
    logic [NW-1:0]           rank_reg, seen_reg;
    logic [CW-1:0]           col_reg, colr_reg;
    logic [HW-1:0]           hl_reg, hr_reg;
    logic [OW-1:0]           occ_reg;
    logic [NW-1:0]           gnd_reg;
    kmsm_pkg::outcome_t      out_code_reg;
    logic                    res_valid_reg;
    logic [kmsm_pkg::OUTCOME_W-1:0]  res_outcome_reg;
    logic [kmsm_pkg::COLUMN_W-1:0]   res_col_reg;
    logic [kmsm_pkg::OCCUPIED_W-1:0] res_occ_reg;
    logic [kmsm_pkg::COUNT_W-1:0]    res_gnd_reg, res_ads_reg, res_des_reg;

    logic [CW-1:0]           h_raddr, h_waddr;
    logic [HW-1:0]           h_rdata, h_wdata;
    logic                    h_wen;
    logic [AW-1:0]           c_raddr, c_waddr;
    logic [KW-1:0]           c_rdata, c_wdata;
    logic                    c_wen;
    kmsm_pkg::pair_flags_t   pair;
    logic [CW-1:0]           pair_col;
    logic [HW-1:0]           pair_hl, pair_hr;

    logic [TW-1:0]           total;
    logic [TW-1:0]           pick;
    logic                    match;
    logic [1:0]              g;
    logic [LW-1:0]           lim;
    logic                    accepted;
    logic                    overflow;

    kmsm_ram #(.WIDTH(HW), .DEPTH(COLUMNS)) u_height_ram (
        .clk   (clk),
        .wen   (h_wen),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    kmsm_ram #(.WIDTH(KW), .DEPTH(COLUMNS * MAX_HEIGHT)) u_cell_ram (
        .clk   (clk),
        .wen   (c_wen),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    kmsm_scan #(.COLUMNS(COLUMNS), .MAX_HEIGHT(MAX_HEIGHT)) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .h_raddr  (h_raddr),
        .h_rdata  (h_rdata),
        .c_raddr  (c_raddr),
        .c_rdata  (c_rdata),
        .pair     (pair),
        .pair_col (pair_col),
        .pair_hl  (pair_hl),
        .pair_hr  (pair_hr)
    );

    assign cfg_ready  = 1'b1;
    assign item_stall = (state_reg != ST_IDLE);

    assign total = TW'(n_ads_reg) + TW'(n_des_reg);
    assign pick  = prod_reg[TW+SW-1:SW];
    assign match = ads_reg ? pair.adsorbable : pair.desorbable;

    always_comb
    begin
        if (ads_reg)
        begin
            g   = {1'b0, hl_reg == '0} + {1'b0, hr_reg == '0};
            lim = ads_lim_reg[g];
        end
        else
        begin
            g   = {1'b0, hl_reg == HW'(1)} + {1'b0, hr_reg == HW'(1)};
            lim = des_lim_reg[g];
        end
        accepted = ({1'b0, acc_reg} < lim);
        overflow = (hl_reg >= HW'(MAX_HEIGHT)) || (hr_reg >= HW'(MAX_HEIGHT));
    end

    always_comb
    begin
        h_wen   = 1'b0;
        h_waddr = clr_reg;
        h_wdata = '0;
        c_wen   = 1'b0;
        c_waddr = AW'(col_reg) * AW'(MAX_HEIGHT) + AW'(hl_reg);
        c_wdata = KW'(kmsm_pkg::CELL_HEAD);
        case (state_reg)
            ST_CLEAR:
            begin
                h_wen = 1'b1;
            end
            ST_WRITE_LEFT:
            begin
                h_wen   = 1'b1;
                h_waddr = col_reg;
                h_wdata = ads_reg ? hl_reg + HW'(1) : hl_reg - HW'(1);
                c_wen   = ads_reg;
            end
            ST_WRITE_RIGHT:
            begin
                h_wen   = 1'b1;
                h_waddr = colr_reg;
                h_wdata = ads_reg ? hr_reg + HW'(1) : hr_reg - HW'(1);
                c_wen   = ads_reg;
                c_waddr = AW'(colr_reg) * AW'(MAX_HEIGHT) + AW'(hr_reg);
                c_wdata = KW'(hl_reg) + KW'(kmsm_pkg::CELL_BODY_BASE);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            for (int i = 0; i < 3; i++)
            begin
                ads_lim_reg[i] <= '0;
                des_lim_reg[i] <= '0;
            end
            clr_reg         <= '0;
            sel_reg         <= '0;
            acc_reg         <= '0;
            start_reg       <= 1'b0;
            n_ads_reg       <= '0;
            n_des_reg       <= '0;
            prod_reg        <= '0;
            ads_reg         <= 1'b0;
            rank_reg        <= '0;
            seen_reg        <= '0;
            col_reg         <= '0;
            colr_reg        <= '0;
            hl_reg          <= '0;
            hr_reg          <= '0;
            occ_reg         <= '0;
            gnd_reg         <= '0;
            out_code_reg    <= kmsm_pkg::OUTCOME_NONE;
            res_valid_reg   <= 1'b0;
            res_outcome_reg <= '0;
            res_col_reg     <= '0;
            res_occ_reg     <= '0;
            res_gnd_reg     <= '0;
            res_ads_reg     <= '0;
            res_des_reg     <= '0;
        end
        else
        begin
            start_reg <= 1'b0;

            if (cfg_valid)
            begin
                case (cfg_index)
                    kmsm_pkg::CFG_ADS_NO_GROUND:  ads_lim_reg[0] <= cfg_data;
                    kmsm_pkg::CFG_ADS_ONE_GROUND: ads_lim_reg[1] <= cfg_data;
                    kmsm_pkg::CFG_ADS_TWO_GROUND: ads_lim_reg[2] <= cfg_data;
                    kmsm_pkg::CFG_DES_NO_GROUND:  des_lim_reg[0] <= cfg_data;
                    kmsm_pkg::CFG_DES_ONE_GROUND: des_lim_reg[1] <= cfg_data;
                    kmsm_pkg::CFG_DES_TWO_GROUND: des_lim_reg[2] <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            if (state_reg == ST_OUT && (!res_valid_reg || !result_stall))
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + CW'(1);
                    if (clr_reg == CW'(COLUMNS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (item_valid)
                    begin
                        sel_reg   <= select_random;
                        acc_reg   <= accept_random;
                        n_ads_reg <= '0;
                        n_des_reg <= '0;
                        start_reg <= 1'b1;
                        state_reg <= ST_COUNT;
                    end
                end
                ST_COUNT:
                begin
                    if (pair.valid)
                    begin
                        n_ads_reg <= n_ads_reg + NW'(pair.adsorbable);
                        n_des_reg <= n_des_reg + NW'(pair.desorbable);
                        if (pair.last)
                        begin
                            state_reg <= ST_MULT;
                        end
                    end
                end
                ST_MULT:
                begin
                    prod_reg  <= (TW+SW)'(total) * (TW+SW)'(sel_reg);
                    state_reg <= ST_SETUP;
                end
                ST_SETUP:
                begin
                    seen_reg <= '0;
                    col_reg  <= '0;
                    if (total == '0)
                    begin
                        out_code_reg <= kmsm_pkg::OUTCOME_NONE;
                        state_reg    <= ST_OUT;
                    end
                    else
                    begin
                        ads_reg   <= (pick < TW'(n_ads_reg));
                        rank_reg  <= (pick < TW'(n_ads_reg)) ? NW'(pick)
                                                              : NW'(pick - TW'(n_ads_reg));
                        start_reg <= 1'b1;
                        state_reg <= ST_LOCATE;
                    end
                end
                ST_LOCATE:
                begin
                    if (pair.valid)
                    begin
                        if (match)
                        begin
                            if (seen_reg == rank_reg)
                            begin
                                col_reg <= pair_col;
                                hl_reg  <= pair_hl;
                                hr_reg  <= pair_hr;
                            end
                            seen_reg <= seen_reg + NW'(1);
                        end
                        if (pair.last)
                        begin
                            state_reg <= ST_DECIDE;
                        end
                    end
                end
                ST_DECIDE:
                begin
                    colr_reg  <= (col_reg == CW'(COLUMNS - 1)) ? '0 : col_reg + CW'(1);
                    state_reg <= ST_OUT;
                    if (ads_reg)
                    begin
                        if (!accepted)
                        begin
                            out_code_reg <= kmsm_pkg::OUTCOME_ADS_REJECTED;
                        end
                        else if (overflow)
                        begin
                            out_code_reg <= kmsm_pkg::OUTCOME_ADS_UNDONE;
                        end
                        else
                        begin
                            out_code_reg <= kmsm_pkg::OUTCOME_ADS_DONE;
                            occ_reg      <= occ_reg + OW'(2);
                            gnd_reg      <= gnd_reg + NW'(g);
                            state_reg    <= ST_WRITE_LEFT;
                        end
                    end
                    else
                    begin
                        if (!accepted)
                        begin
                            out_code_reg <= kmsm_pkg::OUTCOME_DES_REJECTED;
                        end
                        else
                        begin
                            out_code_reg <= kmsm_pkg::OUTCOME_DES_DONE;
                            occ_reg      <= occ_reg - OW'(2);
                            gnd_reg      <= gnd_reg - NW'(g);
                            state_reg    <= ST_WRITE_LEFT;
                        end
                    end
                end
                ST_WRITE_LEFT:
                begin
                    state_reg <= ST_WRITE_RIGHT;
                end
                ST_WRITE_RIGHT:
                begin
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!res_valid_reg || !result_stall)
                    begin
                        res_outcome_reg <= out_code_reg;
                        res_col_reg     <= kmsm_pkg::COLUMN_W'(col_reg);
                        res_occ_reg     <= kmsm_pkg::OCCUPIED_W'(occ_reg);
                        res_gnd_reg     <= kmsm_pkg::COUNT_W'(gnd_reg);
                        res_ads_reg     <= kmsm_pkg::COUNT_W'(n_ads_reg);
                        res_des_reg     <= kmsm_pkg::COUNT_W'(n_des_reg);
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid      = res_valid_reg;
    assign outcome           = res_outcome_reg;
    assign event_column      = res_col_reg;
    assign occupied_sites    = res_occ_reg;
    assign ground_sites      = res_gnd_reg;
    assign adsorbable_pairs  = res_ads_reg;
    assign desorbable_dimers = res_des_reg;

endmodule
